[rtl/triangle_face_normal_top_defines.svh]
// ----------------------------------------------------------------------------
// Triangle face normal assertion macros
// Shared concurrent assertion forms for the face normal checker.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_TOP_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_TOP_DEFINES_SVH

// When the antecedent holds, the consequent must hold in the same cycle.
`define TFN_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// When the antecedent holds, the condition must have held at the past sample chosen by depth.
`define TFN_ASSERT_PAST(label, clk, rst, ante, cond, depth, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> $past(cond, depth)) \
      else $error(msg);

`endif

[rtl/tfn_pkg.sv]
// ----------------------------------------------------------------------------
// Triangle face normal package
// Constants and types shared by the face normal pipeline and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfn_pkg;

   // Normalized magnitudes carry their leading one at this bit count.
   localparam int NORM_TOP  = 30;
   // Sum of three squares of normalized magnitudes.
   localparam int SUM_BITS  = 2 * NORM_TOP + 2;
   // Root bits, one per sqrt cell.
   localparam int SQRT_BITS = SUM_BITS / 2;
   // Partial remainder of the root extraction.
   localparam int SQ_REM_W  = SQRT_BITS + 3;
   // Divisor (twice the root) and division remainder.
   localparam int DIV_W     = SQRT_BITS + 1;

   typedef logic [NORM_TOP-1:0] tfn_u_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       degen;
   } tfn_tag_type;

   typedef struct packed {
      tfn_u_type [2:0] u;
      tfn_tag_type     tag;
   } tfn_pay_type;

endpackage

[rtl/tfn_norm_cell.sv]
// ----------------------------------------------------------------------------
// Normalizer cell
// One step of the left-normalizing shifter: shifts all three magnitudes by a
// fixed amount when their common top bits are clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfn_norm_cell #(
   parameter int W     = 35,
   parameter int SHIFT = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [2:0][W-1:0]     in_mag,
   input  tfn_pkg::tfn_tag_type  in_tag,
   output logic                  out_valid,
   output logic [2:0][W-1:0]     out_mag,
   output tfn_pkg::tfn_tag_type  out_tag
);
   import tfn_pkg::*;

   logic              valid_ff;
   logic [2:0][W-1:0] mag_ff, mag_in;
   tfn_tag_type       tag_ff;
   logic              top_busy;

   always_comb begin
      top_busy = |(in_mag[0][W-1 -: SHIFT] | in_mag[1][W-1 -: SHIFT]
                   | in_mag[2][W-1 -: SHIFT]);
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = top_busy ? in_mag[i] : (in_mag[i] << SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      mag_ff <= mag_in;
      tag_ff <= in_tag;
   end

   assign out_valid = valid_ff;
   assign out_mag   = mag_ff;
   assign out_tag   = tag_ff;

endmodule

[rtl/tfn_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step of the integer square root: brings in two bits of the
// sum and decides one root bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfn_sqrt_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [tfn_pkg::SQ_REM_W-1:0]      in_rem,
   input  logic [tfn_pkg::SQRT_BITS-1:0]     in_root,
   input  logic [tfn_pkg::SUM_BITS-1:0]      in_sum,
   input  tfn_pkg::tfn_pay_type              in_pay,
   output logic                              out_valid,
   output logic [tfn_pkg::SQ_REM_W-1:0]      out_rem,
   output logic [tfn_pkg::SQRT_BITS-1:0]     out_root,
   output logic [tfn_pkg::SUM_BITS-1:0]      out_sum,
   output tfn_pkg::tfn_pay_type              out_pay
);
   import tfn_pkg::*;

   logic                 valid_ff;
   logic [SQ_REM_W-1:0]  rem_ff, rem_in;
   logic [SQRT_BITS-1:0] root_ff, root_in;
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   tfn_pay_type          pay_ff;
   logic [SQ_REM_W-1:0]  take, trial;
   logic                 ge;

   always_comb begin
      take    = {in_rem[SQ_REM_W-3:0], in_sum[SUM_BITS-1 -: 2]};
      trial   = SQ_REM_W'({in_root, 2'b01});
      ge      = take >= trial;
      rem_in  = ge ? (take - trial) : take;
      root_in = {in_root[SQRT_BITS-2:0], ge};
      sum_in  = in_sum << 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      sum_ff  <= sum_in;
      pay_ff  <= in_pay;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_sum   = sum_ff;
   assign out_pay   = pay_ff;

endmodule

[rtl/tfn_div_cell.sv]
// ----------------------------------------------------------------------------
// Divider cell
// One restoring long-division step for three lanes that share a divisor and
// the low dividend bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfn_div_cell #(
   parameter int QB = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [2:0][tfn_pkg::DIV_W-1:0]      in_rem,
   input  logic [2:0][QB-1:0]                  in_quo,
   input  logic [QB-1:0]                       in_nlow,
   input  logic [tfn_pkg::DIV_W-1:0]           in_den,
   input  tfn_pkg::tfn_tag_type                in_tag,
   output logic                                out_valid,
   output logic [2:0][tfn_pkg::DIV_W-1:0]      out_rem,
   output logic [2:0][QB-1:0]                  out_quo,
   output logic [QB-1:0]                       out_nlow,
   output logic [tfn_pkg::DIV_W-1:0]           out_den,
   output tfn_pkg::tfn_tag_type                out_tag
);
   import tfn_pkg::*;

   logic                  valid_ff;
   logic [2:0][DIV_W-1:0] rem_ff, rem_in;
   logic [2:0][QB-1:0]    quo_ff, quo_in;
   logic [QB-1:0]         nlow_ff, nlow_in;
   logic [DIV_W-1:0]      den_ff;
   tfn_tag_type           tag_ff;
   logic [DIV_W:0]        take, diff;
   logic                  ge;

   always_comb begin
      take = '0;
      diff = '0;
      ge   = 1'b0;
      for (int i = 0; i < 3; i++) begin
         take      = {in_rem[i], in_nlow[QB-1]};
         diff      = take - {1'b0, in_den};
         ge        = take >= {1'b0, in_den};
         rem_in[i] = ge ? diff[DIV_W-1:0] : take[DIV_W-1:0];
         quo_in[i] = {in_quo[i][QB-2:0], ge};
      end
      nlow_in = in_nlow << 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      nlow_ff <= nlow_in;
      den_ff  <= in_den;
      tag_ff  <= in_tag;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_nlow  = nlow_ff;
   assign out_den   = den_ff;
   assign out_tag   = tag_ff;

endmodule

[rtl/triangle_face_normal_top.sv]
// ----------------------------------------------------------------------------
// Triangle face normal
// Fully pipelined unit face normal of one triangle given its three corners.
// ----------------------------------------------------------------------------
// A request carries the corners a, b and c in signed fixed point with eight
// fraction bits. It is taken at a rising edge where start is high and busy is
// low. Busy is high only while reset is asserted, so one request may enter in
// every cycle.
// The block forms side1 = b - c and side2 = c - a, their exact cross product,
// and scales it to unit length. Each component comes out signed with
// NORMAL_FRAC_BITS fraction bits. A zero cross product gives a zero normal
// with rsp_degenerate set.
// Every request yields one response, shown for exactly one cycle with
// rsp_valid high, in request order. The pipeline holds a chain of root
// cells (one root bit per cell) and a chain of divider cells (one quotient
// bit per cell). Throughput is one request per cycle.
// The receiver cannot stall. A synchronous reset empties the pipeline;
// requests in flight are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_face_normal_top #(
   parameter int COORD_BITS       = 16,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [COORD_BITS-1:0]       req_a_x,
   input  logic signed [COORD_BITS-1:0]       req_a_y,
   input  logic signed [COORD_BITS-1:0]       req_a_z,
   input  logic signed [COORD_BITS-1:0]       req_b_x,
   input  logic signed [COORD_BITS-1:0]       req_b_y,
   input  logic signed [COORD_BITS-1:0]       req_b_z,
   input  logic signed [COORD_BITS-1:0]       req_c_x,
   input  logic signed [COORD_BITS-1:0]       req_c_y,
   input  logic signed [COORD_BITS-1:0]       req_c_z,
   output logic                               rsp_valid,
   output logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_x,
   output logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_y,
   output logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_z,
   output logic                               rsp_degenerate
);
   import tfn_pkg::*;

   localparam int SIDE_W  = COORD_BITS + 1;
   localparam int PROD_W  = 2 * SIDE_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int NSTEPS  = $clog2(CROSS_W);
   localparam int QB      = NORMAL_FRAC_BITS + 1;
   localparam int OUT_W   = NORMAL_FRAC_BITS + 2;
   localparam int NFW     = NORM_TOP + QB + 1;
   localparam int EXT_W   = CROSS_W + NORM_TOP;

   logic accept;

   assign busy   = reset;
   assign accept = start && !busy;

   // Sides of the triangle.
   logic                     side_valid_ff;
   logic signed [SIDE_W-1:0] side1_ff [3];
   logic signed [SIDE_W-1:0] side2_ff [3];
   logic signed [SIDE_W-1:0] side1_in [3];
   logic signed [SIDE_W-1:0] side2_in [3];

   always_comb begin
      side1_in[0] = SIDE_W'(req_b_x) - SIDE_W'(req_c_x);
      side1_in[1] = SIDE_W'(req_b_y) - SIDE_W'(req_c_y);
      side1_in[2] = SIDE_W'(req_b_z) - SIDE_W'(req_c_z);
      side2_in[0] = SIDE_W'(req_c_x) - SIDE_W'(req_a_x);
      side2_in[1] = SIDE_W'(req_c_y) - SIDE_W'(req_a_y);
      side2_in[2] = SIDE_W'(req_c_z) - SIDE_W'(req_a_z);
   end

   // The six partial products of the cross product.
   logic                     prod_valid_ff;
   logic signed [PROD_W-1:0] prod_ff [6];
   logic signed [PROD_W-1:0] prod_in [6];

   always_comb begin
      prod_in[0] = side1_ff[1] * side2_ff[2];
      prod_in[1] = side1_ff[2] * side2_ff[1];
      prod_in[2] = side1_ff[2] * side2_ff[0];
      prod_in[3] = side1_ff[0] * side2_ff[2];
      prod_in[4] = side1_ff[0] * side2_ff[1];
      prod_in[5] = side1_ff[1] * side2_ff[0];
   end

   // Exact cross product.
   logic                      cross_valid_ff;
   logic signed [CROSS_W-1:0] cross_ff [3];
   logic signed [CROSS_W-1:0] cross_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cross_in[i] = CROSS_W'(prod_ff[2*i]) - CROSS_W'(prod_ff[2*i+1]);
      end
   end

   // Magnitudes and signs; the degenerate case is flagged here.
   logic                      mag_valid_ff;
   logic [2:0][CROSS_W-1:0]   mag_ff, mag_in;
   tfn_tag_type               mag_tag_ff, mag_tag_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_tag_in.neg[i] = cross_ff[i][CROSS_W-1];
         mag_in[i] = cross_ff[i][CROSS_W-1] ? CROSS_W'(-cross_ff[i])
                                            : CROSS_W'(cross_ff[i]);
      end
      mag_tag_in.degen = (cross_ff[0] == '0) && (cross_ff[1] == '0)
                         && (cross_ff[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_valid_ff  <= 1'b0;
         prod_valid_ff  <= 1'b0;
         cross_valid_ff <= 1'b0;
         mag_valid_ff   <= 1'b0;
      end else begin
         side_valid_ff  <= accept;
         prod_valid_ff  <= side_valid_ff;
         cross_valid_ff <= prod_valid_ff;
         mag_valid_ff   <= cross_valid_ff;
      end
      side1_ff   <= side1_in;
      side2_ff   <= side2_in;
      prod_ff    <= prod_in;
      cross_ff   <= cross_in;
      mag_ff     <= mag_in;
      mag_tag_ff <= mag_tag_in;
   end

   // Normalizer chain: each cell halves the remaining shift range, so the
   // common leading one ends up in the top bit.
   logic                    norm_valid [NSTEPS+1];
   logic [2:0][CROSS_W-1:0] norm_mag   [NSTEPS+1];
   tfn_tag_type             norm_tag   [NSTEPS+1];

   assign norm_valid[0] = mag_valid_ff;
   assign norm_mag[0]   = mag_ff;
   assign norm_tag[0]   = mag_tag_ff;

   for (genvar k = 0; k < NSTEPS; k++) begin : g_norm
      tfn_norm_cell #(
         .W     (CROSS_W),
         .SHIFT (1 << (NSTEPS - 1 - k))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (norm_valid[k]),
         .in_mag    (norm_mag[k]),
         .in_tag    (norm_tag[k]),
         .out_valid (norm_valid[k+1]),
         .out_mag   (norm_mag[k+1]),
         .out_tag   (norm_tag[k+1])
      );
   end

   // The top NORM_TOP bits of the normalized magnitudes, zero filled below.
   logic                      u_valid_ff;
   tfn_pay_type               u_pay_ff, u_pay_in;
   logic [EXT_W-1:0]          ext;

   always_comb begin
      ext = '0;
      for (int i = 0; i < 3; i++) begin
         ext            = {norm_mag[NSTEPS][i], NORM_TOP'(0)};
         u_pay_in.u[i]  = ext[EXT_W-1 -: NORM_TOP];
      end
      u_pay_in.tag = norm_tag[NSTEPS];
   end

   // Squares, then their sum.
   logic                        sq_valid_ff;
   logic [2:0][2*NORM_TOP-1:0]  sq_ff, sq_in;
   tfn_pay_type                 sq_pay_ff;
   logic                        sum_valid_ff;
   logic [SUM_BITS-1:0]         sum_ff, sum_in;
   tfn_pay_type                 sum_pay_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = u_pay_ff.u[i] * u_pay_ff.u[i];
      end
      sum_in = SUM_BITS'(sq_ff[0]) + SUM_BITS'(sq_ff[1]) + SUM_BITS'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_valid_ff   <= 1'b0;
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         u_valid_ff   <= norm_valid[NSTEPS];
         sq_valid_ff  <= u_valid_ff;
         sum_valid_ff <= sq_valid_ff;
      end
      u_pay_ff   <= u_pay_in;
      sq_ff      <= sq_in;
      sq_pay_ff  <= u_pay_ff;
      sum_ff     <= sum_in;
      sum_pay_ff <= sq_pay_ff;
   end

   // Root chain: one root bit per cell, most significant first.
   logic                 sqrt_valid [SQRT_BITS+1];
   logic [SQ_REM_W-1:0]  sqrt_rem   [SQRT_BITS+1];
   logic [SQRT_BITS-1:0] sqrt_root  [SQRT_BITS+1];
   logic [SUM_BITS-1:0]  sqrt_sum   [SQRT_BITS+1];
   tfn_pay_type          sqrt_pay   [SQRT_BITS+1];

   assign sqrt_valid[0] = sum_valid_ff;
   assign sqrt_rem[0]   = '0;
   assign sqrt_root[0]  = '0;
   assign sqrt_sum[0]   = sum_ff;
   assign sqrt_pay[0]   = sum_pay_ff;

   for (genvar k = 0; k < SQRT_BITS; k++) begin : g_sqrt
      tfn_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sqrt_valid[k]),
         .in_rem    (sqrt_rem[k]),
         .in_root   (sqrt_root[k]),
         .in_sum    (sqrt_sum[k]),
         .in_pay    (sqrt_pay[k]),
         .out_valid (sqrt_valid[k+1]),
         .out_rem   (sqrt_rem[k+1]),
         .out_root  (sqrt_root[k+1]),
         .out_sum   (sqrt_sum[k+1]),
         .out_pay   (sqrt_pay[k+1])
      );
   end

   // Division setup. The dividend u * 2^QB + r splits into a high part, which
   // is below the divisor 2r, and QB low bits that equal the low bits of r.
   logic                  setup_valid_ff;
   logic [2:0][DIV_W-1:0] setup_rem_ff, setup_rem_in;
   logic [QB-1:0]         setup_nlow_ff, setup_nlow_in;
   logic [DIV_W-1:0]      setup_den_ff, setup_den_in;
   tfn_tag_type           setup_tag_ff;
   logic [NFW-1:0]        nfull;
   logic [SQRT_BITS-1:0]  root;

   always_comb begin
      root  = sqrt_root[SQRT_BITS];
      nfull = '0;
      for (int i = 0; i < 3; i++) begin
         nfull           = NFW'({sqrt_pay[SQRT_BITS].u[i], QB'(0)}) + NFW'(root);
         setup_rem_in[i] = DIV_W'(nfull[NFW-1:QB]);
      end
      setup_nlow_in = nfull[QB-1:0];
      setup_den_in  = {root, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_valid_ff <= 1'b0;
      end else begin
         setup_valid_ff <= sqrt_valid[SQRT_BITS];
      end
      setup_rem_ff  <= setup_rem_in;
      setup_nlow_ff <= setup_nlow_in;
      setup_den_ff  <= setup_den_in;
      setup_tag_ff  <= sqrt_pay[SQRT_BITS].tag;
   end

   // Divider chain: one quotient bit per cell for all three components.
   logic                  div_valid [QB+1];
   logic [2:0][DIV_W-1:0] div_rem   [QB+1];
   logic [2:0][QB-1:0]    div_quo   [QB+1];
   logic [QB-1:0]         div_nlow  [QB+1];
   logic [DIV_W-1:0]      div_den   [QB+1];
   tfn_tag_type           div_tag   [QB+1];

   assign div_valid[0] = setup_valid_ff;
   assign div_rem[0]   = setup_rem_ff;
   assign div_quo[0]   = '0;
   assign div_nlow[0]  = setup_nlow_ff;
   assign div_den[0]   = setup_den_ff;
   assign div_tag[0]   = setup_tag_ff;

   for (genvar k = 0; k < QB; k++) begin : g_div
      tfn_div_cell #(
         .QB (QB)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[k]),
         .in_rem    (div_rem[k]),
         .in_quo    (div_quo[k]),
         .in_nlow   (div_nlow[k]),
         .in_den    (div_den[k]),
         .in_tag    (div_tag[k]),
         .out_valid (div_valid[k+1]),
         .out_rem   (div_rem[k+1]),
         .out_quo   (div_quo[k+1]),
         .out_nlow  (div_nlow[k+1]),
         .out_den   (div_den[k+1]),
         .out_tag   (div_tag[k+1])
      );
   end

   // Response register: apply signs, force zero for a degenerate triangle.
   logic                    rsp_valid_ff;
   logic [2:0][OUT_W-1:0]   norm_out_ff, norm_out_in;
   logic                    degen_ff;
   logic [OUT_W-1:0]        qmag;

   always_comb begin
      qmag = '0;
      for (int i = 0; i < 3; i++) begin
         qmag = OUT_W'(div_quo[QB][i]);
         if (div_tag[QB].degen) begin
            norm_out_in[i] = '0;
         end else if (div_tag[QB].neg[i]) begin
            norm_out_in[i] = -qmag;
         end else begin
            norm_out_in[i] = qmag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid[QB];
      end
      norm_out_ff <= norm_out_in;
      degen_ff    <= div_tag[QB].degen;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normal_x   = norm_out_ff[0];
   assign rsp_normal_y   = norm_out_ff[1];
   assign rsp_normal_z   = norm_out_ff[2];
   assign rsp_degenerate = degen_ff;

endmodule

[rtl/tfn_checker.sv]
// ----------------------------------------------------------------------------
// Triangle face normal checker
// Port-level assertions on latency and response values, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triangle_face_normal_top_defines.svh"

module tfn_checker #(
   parameter int COORD_BITS       = 16,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_x,
   input logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_y,
   input logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_z,
   input logic                               rsp_degenerate
);
   import tfn_pkg::*;

   localparam int OUT_W   = NORMAL_FRAC_BITS + 2;
   localparam int LATENCY = $clog2(2 * COORD_BITS + 3) + NORMAL_FRAC_BITS + 41;
   localparam logic signed [OUT_W-1:0] UNIT_POS = OUT_W'(1) << NORMAL_FRAC_BITS;
   localparam logic signed [OUT_W-1:0] UNIT_NEG = -UNIT_POS;

   // A response appears only if a matching request was accepted earlier.
   `TFN_ASSERT_PAST(a_latency, clock, reset, rsp_valid, start && !busy, LATENCY, "response without matching request")

   // A degenerate triangle gives an all-zero normal.
   `TFN_ASSERT_IMP(a_degen_zero, clock, reset, rsp_valid && rsp_degenerate, rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0, "degenerate normal not zero")

   // A regular triangle never gives an all-zero normal.
   `TFN_ASSERT_IMP(a_nonzero, clock, reset, rsp_valid && !rsp_degenerate, rsp_normal_x != '0 || rsp_normal_y != '0 || rsp_normal_z != '0, "regular normal is zero")

   // Components of a unit vector stay within one.
   `TFN_ASSERT_IMP(a_range, clock, reset, rsp_valid, rsp_normal_x <= UNIT_POS && rsp_normal_x >= UNIT_NEG && rsp_normal_y <= UNIT_POS && rsp_normal_y >= UNIT_NEG && rsp_normal_z <= UNIT_POS && rsp_normal_z >= UNIT_NEG, "normal component out of range")

endmodule

bind triangle_face_normal_top tfn_checker #(
   .COORD_BITS       (COORD_BITS),
   .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_tfn_checker (.*);

[bench/triangle_face_normal_top_tb.sv]
// ----------------------------------------------------------------------------
// Triangle face normal testbench
// Drives triangles into the face normal block and checks each unit normal
// against a bit-exact predictor held in a small scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class normal_board;
   typedef struct {
      logic signed [15:0] nx, ny, nz;
      logic               degen;
   } normal_type;

   normal_type pending[$];
   int         errors;

   function new();
      errors = 0;
   endfunction

   // Integer square root by bit pairs.
   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bit_pos;
      res = 0;
      bit_pos = 64'd1 << 62;
      while (bit_pos > v) bit_pos >>= 2;
      while (bit_pos != 0) begin
         if (v >= res + bit_pos) begin
            v -= res + bit_pos;
            res = (res >> 1) + bit_pos;
         end else begin
            res >>= 1;
         end
         bit_pos >>= 2;
      end
      return res;
   endfunction

   // Note an accepted request: predict its unit normal.
   function void note_triangle(logic signed [15:0] p[9]);
      logic signed [63:0]  s1[3], s2[3];
      logic signed [127:0] cr[3];
      logic [127:0]        mg[3];
      longint unsigned     u[3], sum, r, n;
      int                  len, i, b;
      normal_type          e;
      for (i = 0; i < 3; i++) begin
         s1[i] = 64'(p[3+i]) - 64'(p[6+i]);
         s2[i] = 64'(p[6+i]) - 64'(p[i]);
      end
      cr[0] = 128'(s1[1]) * 128'(s2[2]) - 128'(s1[2]) * 128'(s2[1]);
      cr[1] = 128'(s1[2]) * 128'(s2[0]) - 128'(s1[0]) * 128'(s2[2]);
      cr[2] = 128'(s1[0]) * 128'(s2[1]) - 128'(s1[1]) * 128'(s2[0]);
      len = 0;
      for (i = 0; i < 3; i++) begin
         mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
         for (b = 127; b >= 0; b--)
            if (mg[i][b]) begin
               if (b + 1 > len) len = b + 1;
               break;
            end
      end
      if (len == 0) begin
         e = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
      end else begin
         for (i = 0; i < 3; i++)
            u[i] = len > 30 ? 64'(mg[i] >> (len - 30)) : 64'(mg[i] << (30 - len));
         sum = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
         r = root_floor(sum);
         for (i = 0; i < 3; i++) begin
            n = ((u[i] << 15) + r) / (2 * r);
            if (cr[i] < 0) n = -n;
            if (i == 0) e.nx = n[15:0];
            else if (i == 1) e.ny = n[15:0];
            else e.nz = n[15:0];
         end
         e.degen = 1'b0;
      end
      pending.push_back(e);
   endfunction

   function void check_normal(logic signed [15:0] nx, ny, nz, logic degen);
      normal_type e;
      if (pending.size() == 0) begin
         $error("response with no request outstanding");
         errors++;
         return;
      end
      e = pending.pop_front();
      if (nx !== e.nx) begin $error("normal_x expected %0d got %0d", e.nx, nx); errors++; end
      if (ny !== e.ny) begin $error("normal_y expected %0d got %0d", e.ny, ny); errors++; end
      if (nz !== e.nz) begin $error("normal_z expected %0d got %0d", e.nz, nz); errors++; end
      if (degen !== e.degen) begin
         $error("degenerate expected %0b got %0b", e.degen, degen);
         errors++;
      end
   endfunction
endclass

module triangle_face_normal_top_tb;
   localparam int LATENCY = 61;
   localparam longint CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_a_x = '0, req_a_y = '0, req_a_z = '0;
   logic signed [15:0] req_b_x = '0, req_b_y = '0, req_b_z = '0;
   logic signed [15:0] req_c_x = '0, req_c_y = '0, req_c_z = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic               rsp_degenerate;

   normal_board board = new();
   longint      cycles = 0;

   always #1 clock = ~clock;

   triangle_face_normal_top dut (
      .clock, .reset, .start, .busy,
      .req_a_x, .req_a_y, .req_a_z, .req_b_x, .req_b_y, .req_b_z,
      .req_c_x, .req_c_y, .req_c_z,
      .rsp_valid, .rsp_normal_x, .rsp_normal_y, .rsp_normal_z, .rsp_degenerate
   );

   // Responses cannot be held off, so every strobed cycle is checked at the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_normal(rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_degenerate);
   end

   // The cycle counter ends a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL triangle_face_normal_top");
         $finish;
      end
   end

   // The sender works in bursts; this is how many requests remain in the burst.
   int burst_left = 0;

   // Offer one request and hold it until accepted. Start stays high across
   // back-to-back requests, so it is only lowered during a gap.
   task automatic send_triangle(logic signed [15:0] p[9]);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start   <= 1'b1;
      req_a_x <= p[0]; req_a_y <= p[1]; req_a_z <= p[2];
      req_b_x <= p[3]; req_b_y <= p[4]; req_b_z <= p[5];
      req_c_x <= p[6]; req_c_y <= p[7]; req_c_z <= p[8];
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_triangle(p);
   endtask

   // A coordinate drawn from full range, a narrow range or an extreme.
   function automatic logic signed [15:0] pick_coord(int style);
      case (style)
         0: return 16'($urandom);
         1: return 16'(int'($urandom_range(0, 64)) - 32);
         default: begin
            case ($urandom_range(0, 3))
               0: return 16'sh7FFF;
               1: return 16'sh8000;
               2: return 16'sd0;
               default: return 16'($urandom);
            endcase
         end
      endcase
   endfunction

   initial begin
      logic signed [15:0] p[9];
      int i, k, style;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: all-zero and repeated corners give a degenerate triangle.
      p = '{default: 16'sd0};
      send_triangle(p);
      p = '{default: 16'sh7FFF};
      send_triangle(p);
      p = '{default: 16'sh8000};
      send_triangle(p);
      // Collinear corners are degenerate too.
      p = '{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd256, 16'sd512, 16'sd512, 16'sd512};
      send_triangle(p);
      // Axis-aligned triangles: normal along one axis.
      p = '{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0};
      send_triangle(p);
      p = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 16'sd0};
      send_triangle(p);
      p = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd1, 16'sd0};
      send_triangle(p);
      p = '{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1};
      send_triangle(p);
      // Largest sides: extremes of every field mixed.
      p = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000,
            16'sh8000, 16'sh7FFF, 16'sh7FFF};
      send_triangle(p);
      p = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
            16'sh7FFF, 16'sh7FFF, 16'sh8000};
      send_triangle(p);
      p = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh7FFF,
            16'sh7FFF, 16'sh0000, 16'sh8000};
      send_triangle(p);
      // Tiny triangle: cross product shifted left a long way.
      p = '{16'sd5, 16'sd5, 16'sd5, 16'sd6, 16'sd5, 16'sd5, 16'sd5, 16'sd6, 16'sd6};
      send_triangle(p);

      // Random triangles; some degenerate by repeating a corner.
      for (i = 0; i < 1350; i++) begin
         style = $urandom_range(0, 2);
         for (k = 0; k < 9; k++) p[k] = pick_coord(style);
         if ($urandom_range(0, 19) == 0)
            for (k = 0; k < 3; k++) p[3 + k] = p[6 + k];
         send_triangle(p);
      end
      start <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (board.errors == 0)
         $display("PASS triangle_face_normal_top");
      else
         $display("FAIL triangle_face_normal_top");
      $finish;
   end
endmodule

[sim.f]
+incdir+rtl
rtl/tfn_pkg.sv
rtl/tfn_norm_cell.sv
rtl/tfn_sqrt_cell.sv
rtl/tfn_div_cell.sv
rtl/triangle_face_normal_top.sv
rtl/tfn_checker.sv
bench/triangle_face_normal_top_tb.sv
